### hdl/ptlp_pkg.sv
// Shared constants, types and helpers for the point-to-line projection core.
// No dependencies; every other file in hdl imports this package.
`default_nettype none
package ptlp_pkg;

   localparam int COORD_WIDTH = 16;
   // Differences need one more bit than a coordinate.
   localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
   // Dot products of two differences, plus one carry bit for the sum.
   localparam int DOT_WIDTH   = 2 * DIFF_WIDTH + 1;
   // Magnitude of the product |d| * |num|.
   localparam int PROD_WIDTH  = DIFF_WIDTH + DOT_WIDTH;
   // One divider cell per quotient bit.
   localparam int QUOT_WIDTH  = PROD_WIDTH;
   // Magnitude of the unsigned denominator.
   localparam int DEN_WIDTH   = 2 * DIFF_WIDTH;
   // Partial remainder width in a divider cell.
   localparam int REM_WIDTH   = DEN_WIDTH + 1;
   localparam int TDATA_BYTES = (6 * COORD_WIDTH + 7) / 8;
   localparam int RDATA_BYTES = (2 * COORD_WIDTH + 7) / 8;

   // Payload carried along the divider chain next to the two quotients.
   typedef struct packed {
      logic                          degen;
      logic                          neg_x;
      logic                          neg_y;
      logic signed [COORD_WIDTH-1:0] base_x;
      logic signed [COORD_WIDTH-1:0] base_y;
      logic signed [COORD_WIDTH-1:0] point_y;
   } side_type;

   // State of one lane of the restoring divider.
   typedef struct packed {
      logic [PROD_WIDTH-1:0] dividend;
      logic [REM_WIDTH-1:0]  remainder;
      logic [QUOT_WIDTH-1:0] quotient;
   } lane_type;

endpackage
`default_nettype wire

### hdl/ptlp_div_cell.sv
// One step of the pipelined restoring divider: two lanes sharing a denominator.
// Depends on ptlp_pkg.
`default_nettype none
module ptlp_div_cell
   import ptlp_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 stall,
   input  wire logic                 valid_in,
   input  wire logic [DEN_WIDTH-1:0] den_in,
   input  wire lane_type             lane_x_in,
   input  wire lane_type             lane_y_in,
   input  wire side_type             side_in,
   output logic                      valid_out,
   output logic [DEN_WIDTH-1:0]      den_out,
   output lane_type                  lane_x_out,
   output lane_type                  lane_y_out,
   output side_type                  side_out
);

   logic     valid_ff;
   logic [DEN_WIDTH-1:0] den_ff;
   lane_type lane_x_ff, lane_y_ff, lane_x_in_c, lane_y_in_c;
   side_type side_ff;

   // Shift in the next dividend bit, then subtract the denominator if it fits.
   function automatic lane_type step(lane_type l, logic [DEN_WIDTH-1:0] den);
      lane_type r;
      logic [REM_WIDTH-1:0] trial;
      logic [REM_WIDTH:0]   diff;
      trial = {l.remainder[REM_WIDTH-2:0], l.dividend[PROD_WIDTH-1]};
      diff  = {1'b0, trial} - {2'b00, den};
      r.dividend = {l.dividend[PROD_WIDTH-2:0], 1'b0};
      if (!diff[REM_WIDTH]) begin
         r.remainder = diff[REM_WIDTH-1:0];
         r.quotient  = {l.quotient[QUOT_WIDTH-2:0], 1'b1};
      end else begin
         r.remainder = trial;
         r.quotient  = {l.quotient[QUOT_WIDTH-2:0], 1'b0};
      end
      return r;
   endfunction

   always_comb begin
      lane_x_in_c = step(lane_x_in, den_in);
      lane_y_in_c = step(lane_y_in, den_in);
   end

   // Control bit resets; payload just follows when not stalled.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!stall) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         den_ff    <= den_in;
         lane_x_ff <= lane_x_in_c;
         lane_y_ff <= lane_y_in_c;
         side_ff   <= side_in;
      end
   end

   assign valid_out  = valid_ff;
   assign den_out    = den_ff;
   assign lane_x_out = lane_x_ff;
   assign lane_y_out = lane_y_ff;
   assign side_out   = side_ff;

endmodule
`default_nettype wire

### hdl/point_to_line_projection_core.sv
// Point-to-line projection core: front-end products, a chain of divider
// cells and an output stage with saturation. Depends on ptlp_pkg, ptlp_div_cell.
//
// Usage:
//   req_ channel carries one projection request per transaction: P, A and B.
//   rsp_ channel returns the projected point and a clipped flag in tuser.
//   Results leave in request order, one for every request.
// Pipeline: 3 front-end stages, QUOT_WIDTH (52) divider cells and one output
//   register.
// Throughput: one transaction per cycle while the output is not stalled. The
//   chain of divider cells, one quotient bit per cell, sets the latency; every
//   cell works on a different item in the same cycle.
// Stall: when rsp_tready is low with a valid response held, the whole
//   pipeline holds and req_tready drops; nothing is lost or repeated.
// Reset: synchronous and active high; it empties the pipeline and clears all
//   valid bits. The core is ready for requests in the cycle after reset.
`default_nettype none
module point_to_line_projection_core
   import ptlp_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   // point_x, point_y, line_a_x, line_a_y, line_b_x, line_b_y (low to high)
   input  wire logic [8*TDATA_BYTES-1:0]   req_tdata,
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   // proj_x, proj_y (low to high)
   output logic [8*RDATA_BYTES-1:0]        rsp_tdata,
   // clipped
   output logic                            rsp_tuser
);

   localparam int CW = COORD_WIDTH;
   localparam int NCELL = QUOT_WIDTH;

   logic stall;
   logic out_valid_ff;

   // The pipeline only moves when the output register can be refilled.
   assign stall      = out_valid_ff && !rsp_tready;
   assign req_tready = !reset && !stall;

   logic signed [CW-1:0] px, py, ax, ay, bx, by;
   assign px = req_tdata[0*CW +: CW];
   assign py = req_tdata[1*CW +: CW];
   assign ax = req_tdata[2*CW +: CW];
   assign ay = req_tdata[3*CW +: CW];
   assign bx = req_tdata[4*CW +: CW];
   assign by = req_tdata[5*CW +: CW];

   // Stage 1: differences d = A - B and w = P - B.
   logic s1_valid_ff;
   logic signed [DIFF_WIDTH-1:0] dx_ff, dy_ff, wx_ff, wy_ff;
   logic signed [CW-1:0] s1_bx_ff, s1_by_ff, s1_py_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!stall) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         dx_ff    <= DIFF_WIDTH'(ax) - DIFF_WIDTH'(bx);
         dy_ff    <= DIFF_WIDTH'(ay) - DIFF_WIDTH'(by);
         wx_ff    <= DIFF_WIDTH'(px) - DIFF_WIDTH'(bx);
         wy_ff    <= DIFF_WIDTH'(py) - DIFF_WIDTH'(by);
         s1_bx_ff <= bx;
         s1_by_ff <= by;
         s1_py_ff <= py;
      end
   end

   // Stage 2: num = d.w and den = d.d, one multiplier per product.
   logic s2_valid_ff;
   logic signed [DOT_WIDTH-1:0] num_ff;
   logic [DEN_WIDTH-1:0] den_ff;
   logic signed [DIFF_WIDTH-1:0] s2_dx_ff, s2_dy_ff;
   logic signed [CW-1:0] s2_bx_ff, s2_by_ff, s2_py_ff;
   logic signed [DOT_WIDTH-1:0] p_xx, p_yy, p_dx2, p_dy2;

   always_comb begin
      p_xx  = DOT_WIDTH'(dx_ff * wx_ff);
      p_yy  = DOT_WIDTH'(dy_ff * wy_ff);
      p_dx2 = DOT_WIDTH'(dx_ff * dx_ff);
      p_dy2 = DOT_WIDTH'(dy_ff * dy_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (!stall) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         num_ff   <= p_xx + p_yy;
         den_ff   <= DEN_WIDTH'(p_dx2 + p_dy2);
         s2_dx_ff <= dx_ff;
         s2_dy_ff <= dy_ff;
         s2_bx_ff <= s1_bx_ff;
         s2_by_ff <= s1_by_ff;
         s2_py_ff <= s1_py_ff;
      end
   end

   // Stage 3: magnitude products |d| * |num| and the sign of each quotient.
   logic s3_valid_ff;
   logic [DEN_WIDTH-1:0] s3_den_ff;
   logic [PROD_WIDTH-1:0] mx_ff, my_ff;
   side_type s3_side_ff;
   logic [DIFF_WIDTH-1:0] mag_dx, mag_dy;
   logic [DOT_WIDTH-1:0]  mag_num;

   always_comb begin
      mag_dx  = s2_dx_ff[DIFF_WIDTH-1] ? DIFF_WIDTH'(-s2_dx_ff) : s2_dx_ff;
      mag_dy  = s2_dy_ff[DIFF_WIDTH-1] ? DIFF_WIDTH'(-s2_dy_ff) : s2_dy_ff;
      mag_num = num_ff[DOT_WIDTH-1] ? DOT_WIDTH'(-num_ff) : num_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (!stall) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         s3_den_ff        <= den_ff;
         mx_ff            <= PROD_WIDTH'(mag_dx) * PROD_WIDTH'(mag_num);
         my_ff            <= PROD_WIDTH'(mag_dy) * PROD_WIDTH'(mag_num);
         s3_side_ff.degen <= (den_ff == '0);
         s3_side_ff.neg_x <= s2_dx_ff[DIFF_WIDTH-1] ^ num_ff[DOT_WIDTH-1];
         s3_side_ff.neg_y <= s2_dy_ff[DIFF_WIDTH-1] ^ num_ff[DOT_WIDTH-1];
         s3_side_ff.base_x  <= s2_bx_ff;
         s3_side_ff.base_y  <= s2_by_ff;
         s3_side_ff.point_y <= s2_py_ff;
      end
   end

   // Chain of divider cells, one quotient bit each.
   logic     cv  [NCELL+1];
   logic [DEN_WIDTH-1:0] cd [NCELL+1];
   lane_type clx [NCELL+1];
   lane_type cly [NCELL+1];
   side_type cs  [NCELL+1];

   always_comb begin
      cv[0]  = s3_valid_ff;
      cd[0]  = s3_den_ff;
      clx[0] = '{dividend: mx_ff, remainder: '0, quotient: '0};
      cly[0] = '{dividend: my_ff, remainder: '0, quotient: '0};
      cs[0]  = s3_side_ff;
   end

   for (genvar i = 0; i < NCELL; i++) begin : g_cell
      ptlp_div_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .stall      (stall),
         .valid_in   (cv[i]),
         .den_in     (cd[i]),
         .lane_x_in  (clx[i]),
         .lane_y_in  (cly[i]),
         .side_in    (cs[i]),
         .valid_out  (cv[i+1]),
         .den_out    (cd[i+1]),
         .lane_x_out (clx[i+1]),
         .lane_y_out (cly[i+1]),
         .side_out   (cs[i+1])
      );
   end

   // Output stage: apply signs, add the base point and saturate; a degenerate line gives (base_x, point_y).
   side_type fs;
   logic [QUOT_WIDTH-1:0] qx, qy;
   logic signed [QUOT_WIDTH+1:0] rx, ry;
   logic signed [QUOT_WIDTH+1:0] cmax, cmin;
   logic signed [CW-1:0] ox, oy, cw_max, cw_min;
   logic clip_x, clip_y;
   logic signed [CW-1:0] proj_x_ff, proj_y_ff;
   logic clipped_ff;

   always_comb begin
      fs     = cs[NCELL];
      qx     = clx[NCELL].quotient;
      qy     = cly[NCELL].quotient;
      cw_max = {1'b0, {(CW-1){1'b1}}};
      cw_min = {1'b1, {(CW-1){1'b0}}};
      cmax   = (QUOT_WIDTH+2)'(cw_max);
      cmin   = (QUOT_WIDTH+2)'(cw_min);
      rx = (QUOT_WIDTH+2)'(fs.base_x) +
           (fs.neg_x ? -$signed({2'b00, qx}) : $signed({2'b00, qx}));
      ry = (QUOT_WIDTH+2)'(fs.base_y) +
           (fs.neg_y ? -$signed({2'b00, qy}) : $signed({2'b00, qy}));
      clip_x = 1'b0;
      clip_y = 1'b0;
      if (fs.degen) begin
         ox = fs.base_x;
         oy = fs.point_y;
      end else begin
         if (rx > cmax) begin
            ox = cw_max;
            clip_x = 1'b1;
         end else if (rx < cmin) begin
            ox = cw_min;
            clip_x = 1'b1;
         end else begin
            ox = rx[CW-1:0];
         end
         if (ry > cmax) begin
            oy = cw_max;
            clip_y = 1'b1;
         end else if (ry < cmin) begin
            oy = cw_min;
            clip_y = 1'b1;
         end else begin
            oy = ry[CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (!stall) begin
         out_valid_ff <= cv[NCELL];
      end
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         proj_x_ff  <= ox;
         proj_y_ff  <= oy;
         clipped_ff <= clip_x | clip_y;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = (8*RDATA_BYTES)'({proj_y_ff, proj_x_ff});
   assign rsp_tuser  = clipped_ff;

   // A held response must not change while the receiver stalls.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)
                                       && $stable(rsp_tuser)))
      else $error("response changed during stall");

   // Input is refused exactly when the output is stalled.
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready == !(rsp_tvalid && !rsp_tready))
      else $error("req_tready does not follow the output stall");

   // A degenerate line never reports clipping.
   a_degen: assert property (@(posedge clock) disable iff (reset)
      (!stall && cv[NCELL] && fs.degen) |=> !rsp_tuser)
      else $error("degenerate line flagged as clipped");

endmodule
`default_nettype wire
